@@ rtl/core/irp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irp_pkg
// Shared types, codes and helpers for the identity record parser.
// ----------------------------------------------------------------------------
package irp_pkg;

  localparam int unsigned MaxFieldsDef = 16;
  localparam int unsigned TypeIdLenDef = 24;

  localparam logic [31:0] REC_MAGIC   = 32'h5349_5044;
  localparam logic [7:0]  REC_VERSION = 8'd1;
  localparam int unsigned REC_HDR     = 8;
  localparam int unsigned REC_CRC     = 4;
  localparam int unsigned REC_FIXED   = 3;
  localparam logic [16:0] POS_MAX     = 17'h1FFFF;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

  localparam int unsigned TDATA_W = 88;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BAD   = 3'd1;
  localparam logic [2:0] ST_SIZE  = 3'd2;
  localparam logic [2:0] ST_VER   = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  // item kinds
  localparam logic [2:0] K_IDENT   = 3'd0;
  localparam logic [2:0] K_TYPEID  = 3'd1;
  localparam logic [2:0] K_BAY     = 3'd2;
  localparam logic [2:0] K_RAIL    = 3'd3;
  localparam logic [2:0] K_PROP    = 3'd4;
  localparam logic [2:0] K_SCALAR  = 3'd5;
  localparam logic [2:0] K_PAYLOAD = 3'd6;
  localparam logic [2:0] K_STATUS  = 3'd7;

  // value types
  localparam logic [2:0] VT_BOOL = 3'd0;
  localparam logic [2:0] VT_S64  = 3'd1;
  localparam logic [2:0] VT_U64  = 3'd2;
  localparam logic [2:0] VT_TEXT = 3'd3;
  localparam logic [2:0] VT_BLOB = 3'd4;

  // config register indexes
  localparam logic [2:0] CFG_CODE_BOOL = 3'd0;
  localparam logic [2:0] CFG_CODE_S64  = 3'd1;
  localparam logic [2:0] CFG_CODE_U64  = 3'd2;
  localparam logic [2:0] CFG_CODE_TEXT = 3'd3;
  localparam logic [2:0] CFG_CODE_BLOB = 3'd4;
  localparam logic [2:0] CFG_ID_LIM    = 3'd5;
  localparam logic [2:0] CFG_TEXT_LIM  = 3'd6;
  localparam logic [2:0] CFG_BLOB_LIM  = 3'd7;

  // parse phases
  localparam logic [3:0] PH_HDR     = 4'd0;
  localparam logic [3:0] PH_IDENT   = 4'd1;
  localparam logic [3:0] PH_TYPEID  = 4'd2;
  localparam logic [3:0] PH_BAY     = 4'd3;
  localparam logic [3:0] PH_RAIL    = 4'd4;
  localparam logic [3:0] PH_COUNT   = 4'd5;
  localparam logic [3:0] PH_FID_LO  = 4'd6;
  localparam logic [3:0] PH_FID_HI  = 4'd7;
  localparam logic [3:0] PH_VTYPE   = 4'd8;
  localparam logic [3:0] PH_BOOLV   = 4'd9;
  localparam logic [3:0] PH_INTV    = 4'd10;
  localparam logic [3:0] PH_TLEN    = 4'd11;
  localparam logic [3:0] PH_PAYLOAD = 4'd12;
  localparam logic [3:0] PH_DONE    = 4'd13;
  localparam logic [3:0] PH_SKIP    = 4'd14;

  typedef struct packed {
    logic [2:0]  kind;
    logic        fin;
    logic [2:0]  status;
    logic [2:0]  vtype;
    logic [15:0] fid;
    logic [63:0] data;
  } tok_t;

  typedef struct packed {
    logic step;    // take the input byte
    logic sel_st;  // drive the status item on the output
  } cmd_t;

  typedef struct packed {
    logic has_tok; // the byte yields a token
    logic has_st;  // the byte closes the record
  } sts_t;

  typedef struct packed {
    logic       we;
    logic [2:0] idx;
    logic [7:0] wdata;
  } cfg_t;

  function automatic logic [31:0] crc_feed(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/irp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irp_ctrl
// Handshake sequencer: takes a byte, then drains its token and status.
// ----------------------------------------------------------------------------
module irp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  input  irp_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output irp_pkg::cmd_t cmd_o
);
  import irp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TOK  = 2'd1;
  localparam logic [1:0] S_ST   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       st_pend_q, st_pend_d;

  always_comb begin
    state_d     = state_q;
    st_pend_d   = st_pend_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          st_pend_d  = sts_i.has_st;
          if (sts_i.has_tok) begin
            state_d = S_TOK;
          end else if (sts_i.has_st) begin
            state_d = S_ST;
          end
        end
      end
      S_TOK: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = st_pend_q ? S_ST : S_IDLE;
        end
      end
      S_ST: begin
        out_valid_o  = 1'b1;
        cmd_o.sel_st = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      st_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      st_pend_q <= st_pend_d;
    end
  end

endmodule

@@ rtl/core/irp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irp_datapath
// Record state, CRC, field decode and the held output items.
// ----------------------------------------------------------------------------
module irp_datapath #(
  parameter int unsigned MAX_FIELDS  = irp_pkg::MaxFieldsDef,
  parameter int unsigned TYPE_ID_LEN = irp_pkg::TypeIdLenDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  irp_pkg::cfg_t cfg_i,
  input  irp_pkg::cmd_t cmd_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output irp_pkg::sts_t sts_o,
  output irp_pkg::tok_t out_o
);
  import irp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FIELDS + 1);

  // configuration
  logic [7:0] c_bool_q, c_s64_q, c_u64_q, c_text_q, c_blob_q;
  logic [7:0] id_lim_q, text_lim_q, blob_lim_q;

  // record state
  logic [16:0] pos_q, pos_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] exp_q, exp_d;
  logic [7:0]  ident_q, ident_d;
  logic [15:0] blen_q, blen_d;
  logic [3:0]  ph_q, ph_d;
  logic [2:0]  herr_q, herr_d;
  logic [2:0]  berr_q, berr_d;
  logic [7:0]  rem_q, rem_d;
  logic [63:0] vs_q, vs_d;
  logic [15:0] cf_q, cf_d;
  logic [2:0]  ct_q, ct_d;
  logic [7:0]  pl_q, pl_d;
  logic        nul_q, nul_d;
  logic [15:0] seen_q [MAX_FIELDS];
  logic [15:0] seen_d [MAX_FIELDS];
  logic [CntW-1:0] scnt_q, scnt_d;

  tok_t tok_q, tok_d, st_q, st_d;

  logic [16:0] body_end;
  logic [17:0] crc_end, rec_len, rec_total;
  logic        in_hdr, in_body;
  logic [15:0] fid_new;
  logic        dup;
  logic [2:0]  vt_new;
  logic        vt_ok;
  logic [7:0]  lim;
  logic [63:0] vs_new;
  logic        nul_new;
  logic [2:0]  st_code;
  logic [1:0]  crc_byte;

  always_comb begin
    pos_d  = pos_q;  crc_d  = crc_q;  exp_d = exp_q;  ident_d = ident_q;
    blen_d = blen_q; ph_d   = ph_q;   herr_d = herr_q; berr_d = berr_q;
    rem_d  = rem_q;  vs_d   = vs_q;   cf_d  = cf_q;   ct_d    = ct_q;
    pl_d   = pl_q;   nul_d  = nul_q;  scnt_d = scnt_q;
    seen_d = seen_q;
    tok_d  = '0;
    st_d   = '0;
    sts_o  = '0;
    fid_new = {byte_i, cf_q[7:0]};
    dup     = 1'b0;
    vt_new  = VT_BOOL;
    vt_ok   = 1'b1;
    lim     = (ct_q == VT_TEXT) ? text_lim_q : blob_lim_q;
    vs_new  = vs_q | ({56'd0, byte_i} << {3'(3'd0 - rem_q[2:0]), 3'b000});
    nul_new = nul_q | (byte_i == 8'd0);
    st_code = ST_OK;

    body_end  = {1'b0, blen_q} + 17'(REC_HDR);
    crc_end   = {1'b0, body_end} + 18'(REC_CRC);
    in_hdr    = pos_q < 17'(REC_HDR);
    in_body   = !in_hdr && (pos_q < body_end);
    crc_byte  = 2'(pos_q - body_end);

    for (int i = 0; i < MAX_FIELDS; i++) begin
      if ((CntW'(i) < scnt_q) && (seen_q[i] == fid_new)) dup = 1'b1;
    end
    // first matching code wins
    priority if (byte_i == c_bool_q) vt_new = VT_BOOL;
    else if (byte_i == c_s64_q)      vt_new = VT_S64;
    else if (byte_i == c_u64_q)      vt_new = VT_U64;
    else if (byte_i == c_text_q)     vt_new = VT_TEXT;
    else if (byte_i == c_blob_q)     vt_new = VT_BLOB;
    else                             vt_ok  = 1'b0;

    if (pos_q < POS_MAX) pos_d = pos_q + 17'd1;
    if (in_hdr || in_body) crc_d = crc_feed(crc_q, byte_i);

    if (in_hdr) begin
      unique case (pos_q[2:0])
        3'd0, 3'd1, 3'd2, 3'd3: begin
          if (byte_i != 8'(REC_MAGIC >> {pos_q[1:0], 3'b000}) && herr_q == ST_OK)
            herr_d = ST_BAD;
        end
        3'd4: if (byte_i != REC_VERSION && herr_q == ST_OK) herr_d = ST_VER;
        3'd5: begin
          ident_d = byte_i;
          if ((byte_i == 8'd0 || byte_i > id_lim_q) && herr_q == ST_OK) herr_d = ST_BAD;
        end
        3'd6: blen_d = {8'd0, byte_i};
        default: begin
          blen_d = {byte_i, blen_q[7:0]};
          if ({1'b0, byte_i, blen_q[7:0]} <
              17'(ident_q) + 17'(TYPE_ID_LEN) + 17'(REC_FIXED))
            berr_d = ST_BAD;
          if (herr_q != ST_OK || berr_d != ST_OK) begin
            ph_d = PH_SKIP;
          end else begin
            ph_d  = PH_IDENT;
            rem_d = ident_q;
          end
        end
      endcase
    end else if (in_body) begin
      unique case (ph_q)
        PH_IDENT: begin
          tok_d.kind = K_IDENT; tok_d.data = {56'd0, byte_i}; sts_o.has_tok = 1'b1;
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            ph_d = PH_TYPEID; rem_d = 8'(TYPE_ID_LEN); nul_d = 1'b0;
          end
        end
        PH_TYPEID: begin
          tok_d.kind = K_TYPEID; tok_d.data = {56'd0, byte_i}; sts_o.has_tok = 1'b1;
          nul_d = nul_new;
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            if (!nul_new) begin
              if (berr_q == ST_OK) berr_d = ST_BAD;
              ph_d = PH_SKIP;
            end else begin
              ph_d = PH_BAY;
            end
          end
        end
        PH_BAY: begin
          tok_d.kind = K_BAY; tok_d.data = {56'd0, byte_i}; sts_o.has_tok = 1'b1;
          ph_d = PH_RAIL;
        end
        PH_RAIL: begin
          tok_d.kind = K_RAIL; tok_d.data = {56'd0, byte_i}; sts_o.has_tok = 1'b1;
          ph_d = PH_COUNT;
        end
        PH_COUNT: begin
          if (byte_i > 8'(MAX_FIELDS)) begin
            if (berr_q == ST_OK) berr_d = ST_RANGE;
            ph_d = PH_SKIP;
          end else if (byte_i == 8'd0) begin
            ph_d = PH_DONE;
          end else begin
            pl_d = byte_i; ph_d = PH_FID_LO;
          end
        end
        PH_FID_LO: begin
          cf_d = {8'd0, byte_i}; ph_d = PH_FID_HI;
        end
        PH_FID_HI: begin
          cf_d = fid_new;
          if (fid_new == 16'd0 || dup) begin
            if (berr_q == ST_OK) berr_d = ST_BAD;
            ph_d = PH_SKIP;
          end else begin
            if (scnt_q < CntW'(MAX_FIELDS)) begin
              for (int i = 0; i < MAX_FIELDS; i++) begin
                if (CntW'(i) == scnt_q) seen_d[i] = fid_new;
              end
              scnt_d = scnt_q + CntW'(1);
            end
            ph_d = PH_VTYPE;
          end
        end
        PH_VTYPE: begin
          if (!vt_ok) begin
            if (berr_q == ST_OK) berr_d = ST_BAD;
            ph_d = PH_SKIP;
          end else begin
            ct_d = vt_new;
            tok_d.kind = K_PROP; tok_d.fid = cf_q; tok_d.vtype = vt_new;
            sts_o.has_tok = 1'b1;
            if (vt_new == VT_BOOL) begin
              ph_d = PH_BOOLV;
            end else if (vt_new == VT_S64 || vt_new == VT_U64) begin
              ph_d = PH_INTV; rem_d = 8'd8; vs_d = '0;
            end else begin
              ph_d = PH_TLEN;
            end
          end
        end
        PH_BOOLV: begin
          tok_d.kind = K_SCALAR; tok_d.data = {63'd0, byte_i != 8'd0};
          tok_d.fid = cf_q; tok_d.vtype = ct_q; sts_o.has_tok = 1'b1;
          pl_d = pl_q - 8'd1;
          ph_d = (pl_q == 8'd1) ? PH_DONE : PH_FID_LO;
        end
        PH_INTV: begin
          vs_d  = vs_new;
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            tok_d.kind = K_SCALAR; tok_d.data = vs_new;
            tok_d.fid = cf_q; tok_d.vtype = ct_q; sts_o.has_tok = 1'b1;
            pl_d = pl_q - 8'd1;
            ph_d = (pl_q == 8'd1) ? PH_DONE : PH_FID_LO;
          end
        end
        PH_TLEN: begin
          if (byte_i > lim) begin
            if (berr_q == ST_OK) berr_d = ST_RANGE;
            ph_d = PH_SKIP;
          end else if (byte_i == 8'd0) begin
            pl_d = pl_q - 8'd1;
            ph_d = (pl_q == 8'd1) ? PH_DONE : PH_FID_LO;
          end else begin
            rem_d = byte_i; ph_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          tok_d.kind = K_PAYLOAD; tok_d.data = {56'd0, byte_i};
          tok_d.fid = cf_q; tok_d.vtype = ct_q; sts_o.has_tok = 1'b1;
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            pl_d = pl_q - 8'd1;
            ph_d = (pl_q == 8'd1) ? PH_DONE : PH_FID_LO;
          end
        end
        PH_DONE: begin
          if (berr_q == ST_OK) berr_d = ST_BAD;
          ph_d = PH_SKIP;
        end
        default: begin
        end
      endcase
      // body ran out inside a field
      if (pos_q == body_end - 17'd1 && ph_d != PH_DONE) begin
        if (berr_d == ST_OK) berr_d = ST_BAD;
        ph_d = PH_SKIP;
      end
    end else if ({1'b0, pos_q} < crc_end) begin
      exp_d = exp_q | ({24'd0, byte_i} << {crc_byte, 3'b000});
    end

    rec_len   = {1'b0, pos_q} + 18'd1;
    rec_total = {2'b00, blen_d} + 18'(REC_HDR + REC_CRC);
    priority if (rec_len < 18'(REC_HDR + REC_CRC)) st_code = ST_SIZE;
    else if (herr_d != ST_OK)                      st_code = herr_d;
    else if (rec_total > rec_len)                  st_code = ST_SIZE;
    else if (rec_total < rec_len)                  st_code = ST_BAD;
    else if (~crc_d != exp_d)                      st_code = ST_BAD;
    else                                           st_code = berr_d;

    if (last_i) begin
      sts_o.has_st = 1'b1;
      st_d.kind    = K_STATUS;
      st_d.status  = st_code;
      st_d.fin     = 1'b1;
      pos_d = '0; crc_d = '1; exp_d = '0; ident_d = '0; blen_d = '0;
      ph_d = PH_HDR; herr_d = ST_OK; berr_d = ST_OK; rem_d = '0; vs_d = '0;
      cf_d = '0; ct_d = '0; pl_d = '0; nul_d = 1'b0; scnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_bool_q <= 8'd0; c_s64_q <= 8'd1; c_u64_q <= 8'd2; c_text_q <= 8'd3;
      c_blob_q <= 8'd4; id_lim_q <= 8'd32; text_lim_q <= 8'd32; blob_lim_q <= 8'd32;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_CODE_BOOL: c_bool_q   <= cfg_i.wdata;
        CFG_CODE_S64:  c_s64_q    <= cfg_i.wdata;
        CFG_CODE_U64:  c_u64_q    <= cfg_i.wdata;
        CFG_CODE_TEXT: c_text_q   <= cfg_i.wdata;
        CFG_CODE_BLOB: c_blob_q   <= cfg_i.wdata;
        CFG_ID_LIM:    id_lim_q   <= cfg_i.wdata;
        CFG_TEXT_LIM:  text_lim_q <= cfg_i.wdata;
        default:       blob_lim_q <= cfg_i.wdata;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; crc_q <= '1; exp_q <= '0; ident_q <= '0; blen_q <= '0;
      ph_q <= PH_HDR; herr_q <= ST_OK; berr_q <= ST_OK; rem_q <= '0;
      vs_q <= '0; cf_q <= '0; ct_q <= '0; pl_q <= '0; nul_q <= 1'b0;
      scnt_q <= '0;
    end else if (cmd_i.step) begin
      pos_q <= pos_d; crc_q <= crc_d; exp_q <= exp_d; ident_q <= ident_d;
      blen_q <= blen_d; ph_q <= ph_d; herr_q <= herr_d; berr_q <= berr_d;
      rem_q <= rem_d; vs_q <= vs_d; cf_q <= cf_d; ct_q <= ct_d; pl_q <= pl_d;
      nul_q <= nul_d; scnt_q <= scnt_d;
    end
  end

  // id store and held items: payload, qualified by seen count and controller
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      seen_q <= seen_d;
      tok_q  <= tok_d;
      st_q   <= st_d;
    end
  end

  assign out_o = cmd_i.sel_st ? st_q : tok_q;

endmodule

@@ rtl/core/identity_record_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identity_record_parser
// Byte-stream checker and tokenizer for identity records with CRC-32 trailer.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_axis  | in  | tdata[7:0] record byte, tlast = last byte of record
//  m_axis  | out | tuser = kind, tdata = data/fid/vtype/status,
//          |     | tlast = final status item of the record
//  cfg     | in  | we/idx/wdata, eight 8-bit registers
//
//  A byte is taken in the idle state, then its token (if any) and its status (on
//  the last byte) leave one per cycle while m_axis_tready is high, drained by the
//  controller from the single-entry token and status holds in the datapath.
//  Reset clears all record state; configuration returns to default codes.
//  s_axis_tready drops while an item waits on m_axis; nothing is dropped.
//  Seen ids need no clearing pass: a fill count qualifies the store.
// ----------------------------------------------------------------------------
module identity_record_parser #(
  parameter int unsigned MAX_FIELDS  = irp_pkg::MaxFieldsDef,
  parameter int unsigned TYPE_ID_LEN = irp_pkg::TypeIdLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [irp_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // [63:0] data, [79:64] fid, [82:80] vtype, [85:83] status, zero pad
  output logic [2:0]  m_axis_tuser_o,   // [2:0] kind
  output logic        m_axis_tlast_o,   // final_res
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);
  import irp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  cfg_t cfg;
  tok_t out_tok;

  assign cfg = '{we: cfg_we_i, idx: cfg_idx_i, wdata: cfg_wdata_i};

  irp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  irp_datapath #(
    .MAX_FIELDS  (MAX_FIELDS),
    .TYPE_ID_LEN (TYPE_ID_LEN)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .sts_o  (sts),
    .out_o  (out_tok)
  );

  assign m_axis_tdata_o = {2'b00, out_tok.status, out_tok.vtype, out_tok.fid, out_tok.data};
  assign m_axis_tuser_o = out_tok.kind;
  assign m_axis_tlast_o = out_tok.fin;

  // one byte in flight: never take a byte while an item is shown
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while output pending");

  // a record end is always followed by an output item
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("record end produced no item");

  // final flag only on the status kind, and status zero elsewhere
  a_final_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == K_STATUS)))
    else $error("final flag on non-status item");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != K_STATUS) |-> (m_axis_tdata_o[85:83] == ST_OK))
    else $error("status set on token item");

endmodule

@@ bench/identity_record_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identity_record_parser_tb
// Self-checking bench for the identity record parser. Records are built as
// byte streams: well-formed ones with random identities and properties,
// broken ones with corrupted headers, lengths, CRCs and fields, plus raw
// noise. A behavioral tokenizer predicts the item stream, and a monitor
// compares every output item field by field. Both stream sides idle at
// random rates, and the type codes and limits change between phases.
// ----------------------------------------------------------------------------
module identity_record_parser_tb;
  import irp_pkg::*;

  localparam int unsigned NFIELDS = MaxFieldsDef;
  localparam int unsigned TIDLEN  = TypeIdLenDef;
  localparam int unsigned IDLE_LIMIT = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] data_byte
  logic        s_axis_tlast_i;   // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;
  // [63:0] data, [79:64] fid, [82:80] vtype, [85:83] status, zero pad
  logic [2:0]  m_axis_tuser_o;   // [2:0] kind
  logic        m_axis_tlast_o;   // final_res
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;

  identity_record_parser dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // expected output items, oldest first
  typedef struct {
    logic [2:0]  kind;
    logic [63:0] data;
    logic [15:0] fid;
    logic [2:0]  vtype;
    logic [2:0]  status;
    logic        fin;
  } token_t;

  token_t pending_tokens[$];
  int     fail_count = 0;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     idle_cycles = 0;
  int     bytes_sent = 0;

  // ---------------------------------------------------------------------------
  // Predictor: configuration shadow and per-record parse state
  // ---------------------------------------------------------------------------
  logic [7:0] type_code[5];       // bool, s64, u64, text, blob
  logic [7:0] lim_ident, lim_text, lim_blob;

  logic [16:0] p_pos;
  logic [31:0] p_crc, p_exp_crc;
  logic [7:0]  p_id_len;
  logic [15:0] p_body_len;
  logic [3:0]  p_phase;
  logic [2:0]  p_hdr_err, p_body_err;
  logic [7:0]  p_left;
  logic [63:0] p_shift;
  logic [15:0] p_fid;
  logic [2:0]  p_vtype;
  logic [7:0]  p_props;
  logic        p_nul;
  logic [15:0] p_seen[NFIELDS];
  int          p_seen_n;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  task automatic clear_record();
    p_pos = '0; p_crc = '1; p_exp_crc = '0; p_id_len = '0; p_body_len = '0;
    p_phase = PH_HDR; p_hdr_err = ST_OK; p_body_err = ST_OK; p_left = '0;
    p_shift = '0; p_fid = '0; p_vtype = '0; p_props = '0; p_nul = 1'b0;
    p_seen_n = 0;
  endtask

  task automatic push_token(logic [2:0] k, logic [63:0] d, logic [15:0] f,
                            logic [2:0] vt, logic [2:0] st, logic fin);
    token_t t;
    t.kind = k; t.data = d; t.fid = f; t.vtype = vt; t.status = st; t.fin = fin;
    pending_tokens.push_back(t);
  endtask

  task automatic fail_body(logic [2:0] st);
    if (p_body_err == ST_OK) p_body_err = st;
    p_phase = PH_SKIP;
  endtask

  task automatic finish_prop();
    p_props--;
    p_phase = (p_props == 0) ? PH_DONE : PH_FID_LO;
  endtask

  task automatic parse_body(logic [7:0] b);
    logic dup;
    case (p_phase)
      PH_IDENT: begin
        push_token(K_IDENT, 64'(b), '0, '0, ST_OK, 1'b0);
        p_left--;
        if (p_left == 0) begin
          p_phase = PH_TYPEID; p_left = 8'(TIDLEN); p_nul = 1'b0;
        end
      end
      PH_TYPEID: begin
        push_token(K_TYPEID, 64'(b), '0, '0, ST_OK, 1'b0);
        if (b == 0) p_nul = 1'b1;
        p_left--;
        if (p_left == 0) begin
          if (!p_nul) fail_body(ST_BAD);
          else p_phase = PH_BAY;
        end
      end
      PH_BAY: begin
        push_token(K_BAY, 64'(b), '0, '0, ST_OK, 1'b0);
        p_phase = PH_RAIL;
      end
      PH_RAIL: begin
        push_token(K_RAIL, 64'(b), '0, '0, ST_OK, 1'b0);
        p_phase = PH_COUNT;
      end
      PH_COUNT: begin
        if (b > NFIELDS) fail_body(ST_RANGE);
        else if (b == 0) p_phase = PH_DONE;
        else begin
          p_props = b; p_phase = PH_FID_LO;
        end
      end
      PH_FID_LO: begin
        p_fid = {8'd0, b}; p_phase = PH_FID_HI;
      end
      PH_FID_HI: begin
        p_fid[15:8] = b;
        dup = 1'b0;
        for (int i = 0; i < p_seen_n; i++) if (p_seen[i] == p_fid) dup = 1'b1;
        if (p_fid == 0 || dup) fail_body(ST_BAD);
        else begin
          if (p_seen_n < NFIELDS) begin
            p_seen[p_seen_n] = p_fid; p_seen_n++;
          end
          p_phase = PH_VTYPE;
        end
      end
      PH_VTYPE: begin
        // first matching code wins when codes are shared
        if (b == type_code[0]) p_vtype = VT_BOOL;
        else if (b == type_code[1]) p_vtype = VT_S64;
        else if (b == type_code[2]) p_vtype = VT_U64;
        else if (b == type_code[3]) p_vtype = VT_TEXT;
        else if (b == type_code[4]) p_vtype = VT_BLOB;
        else p_vtype = 3'd7;
        if (p_vtype == 3'd7) fail_body(ST_BAD);
        else begin
          push_token(K_PROP, '0, p_fid, p_vtype, ST_OK, 1'b0);
          if (p_vtype == VT_BOOL) p_phase = PH_BOOLV;
          else if (p_vtype == VT_S64 || p_vtype == VT_U64) begin
            p_phase = PH_INTV; p_left = 8'd8; p_shift = '0;
          end else p_phase = PH_TLEN;
        end
      end
      PH_BOOLV: begin
        push_token(K_SCALAR, 64'(b != 0), p_fid, p_vtype, ST_OK, 1'b0);
        finish_prop();
      end
      PH_INTV: begin
        p_shift[8*(8-p_left) +: 8] = b;
        p_left--;
        if (p_left == 0) begin
          push_token(K_SCALAR, p_shift, p_fid, p_vtype, ST_OK, 1'b0);
          finish_prop();
        end
      end
      PH_TLEN: begin
        if (b > ((p_vtype == VT_TEXT) ? lim_text : lim_blob)) fail_body(ST_RANGE);
        else if (b == 0) finish_prop();
        else begin
          p_left = b; p_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        push_token(K_PAYLOAD, 64'(b), p_fid, p_vtype, ST_OK, 1'b0);
        p_left--;
        if (p_left == 0) finish_prop();
      end
      PH_DONE: fail_body(ST_BAD);
      default: ;
    endcase
  endtask

  task automatic predict_byte(logic [7:0] b, logic last);
    int pos, body_end, len, total;
    logic [2:0] st;
    pos = int'(p_pos);
    body_end = REC_HDR + int'(p_body_len);
    if (p_pos != POS_MAX) p_pos++;
    if (pos < REC_HDR || pos < body_end) p_crc = crc_byte(p_crc, b);
    if (pos < 4) begin
      if (b != REC_MAGIC[8*pos +: 8] && p_hdr_err == ST_OK) p_hdr_err = ST_BAD;
    end else if (pos == 4) begin
      if (b != REC_VERSION && p_hdr_err == ST_OK) p_hdr_err = ST_VER;
    end else if (pos == 5) begin
      p_id_len = b;
      if ((b == 0 || b > lim_ident) && p_hdr_err == ST_OK) p_hdr_err = ST_BAD;
    end else if (pos == 6) begin
      p_body_len = {8'd0, b};
    end else if (pos == 7) begin
      p_body_len[15:8] = b;
      if (int'(p_body_len) < int'(p_id_len) + TIDLEN + REC_FIXED) p_body_err = ST_BAD;
      if (p_hdr_err != ST_OK || p_body_err != ST_OK) p_phase = PH_SKIP;
      else begin
        p_phase = PH_IDENT; p_left = p_id_len;
      end
    end else if (pos < body_end) begin
      parse_body(b);
      if (pos == body_end - 1 && p_phase != PH_DONE) begin
        if (p_body_err == ST_OK) p_body_err = ST_BAD;
        p_phase = PH_SKIP;
      end
    end else if (pos < body_end + REC_CRC) begin
      p_exp_crc[8*((pos - body_end) & 3) +: 8] = b;
    end
    if (last) begin
      len = pos + 1;
      total = REC_HDR + int'(p_body_len) + REC_CRC;
      if (len < REC_HDR + REC_CRC) st = ST_SIZE;
      else if (p_hdr_err != ST_OK) st = p_hdr_err;
      else if (total > len) st = ST_SIZE;
      else if (total < len) st = ST_BAD;
      else if (~p_crc != p_exp_crc) st = ST_BAD;
      else st = p_body_err;
      push_token(K_STATUS, '0, '0, '0, st, 1'b1);
      clear_record();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // tvalid stays up between back-to-back bytes and drops while idling and after a record's last byte
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_bytes(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // settle before touching configuration
  task automatic drain();
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_CODE_BOOL: type_code[0] = val;
      CFG_CODE_S64:  type_code[1] = val;
      CFG_CODE_U64:  type_code[2] = val;
      CFG_CODE_TEXT: type_code[3] = val;
      CFG_CODE_BLOB: type_code[4] = val;
      CFG_ID_LIM:    lim_ident = val;
      CFG_TEXT_LIM:  lim_text = val;
      default:       lim_blob = val;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Record builder
  // ---------------------------------------------------------------------------
  typedef enum int {
    FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_ID_SIZE, FLAW_SHORT_BODY, FLAW_NO_NUL,
    FLAW_COUNT, FLAW_ZERO_ID, FLAW_DUP_ID, FLAW_BAD_TYPE, FLAW_LEN_RANGE,
    FLAW_TRUNC, FLAW_EXTRA_BODY, FLAW_CRC, FLAW_CUT, FLAW_TAIL, FLAW_LAST
  } flaw_t;

  function automatic logic [7:0] pick_code(int vt);
    return type_code[vt];
  endfunction

  // returns a code that matches no type register, or the bool code if none
  function automatic logic [7:0] unused_code();
    logic [7:0] c;
    for (int k = 0; k < 256; k++) begin
      c = 8'($urandom);
      if (c != type_code[0] && c != type_code[1] && c != type_code[2] &&
          c != type_code[3] && c != type_code[4]) return c;
    end
    return type_code[0];
  endfunction

  task automatic build_record(flaw_t flaw, int nprops, int max_pay,
                              output logic [7:0] rec[$]);
    logic [7:0] body[$];
    logic [7:0] id_len;
    logic [31:0] c;
    logic [15:0] fid, blen;
    int vt, plen, lim;
    id_len = 8'($urandom_range(1, (lim_ident > 6) ? 6 : lim_ident));
    if ($urandom_range(9) == 0) id_len = lim_ident;
    if (flaw == FLAW_ID_SIZE) id_len = ($urandom_range(1) || lim_ident == 255) ? 8'd0
                                                                              : lim_ident + 8'd1;
    body = {};
    repeat (id_len) body.push_back(8'($urandom));
    for (int i = 0; i < TIDLEN; i++) body.push_back(8'($urandom_range(1, 255)));
    if (flaw != FLAW_NO_NUL) body[id_len + $urandom_range(TIDLEN - 1)] = 8'd0;
    body.push_back(8'($urandom)); body.push_back(8'($urandom));
    if (flaw == FLAW_COUNT) body.push_back(8'($urandom_range(NFIELDS + 1, 255)));
    else body.push_back(8'(nprops));
    for (int p = 0; p < nprops; p++) begin
      fid = 16'(p + 1) ^ {1'($urandom_range(1)), 15'd0} ^ (16'($urandom_range(3)) << 8);
      if (fid == 0) fid = 16'h8000 + 16'(p);
      if (p == nprops - 1 && flaw == FLAW_ZERO_ID) fid = '0;
      if (p == nprops - 1 && flaw == FLAW_DUP_ID && p > 0) fid = {body[body.size() - 1], 8'd0};
      body.push_back(fid[7:0]); body.push_back(fid[15:8]);
      vt = $urandom_range(4);
      if (p == nprops - 1 && flaw == FLAW_LEN_RANGE) vt = 3 + $urandom_range(1);
      if (p == nprops - 1 && flaw == FLAW_BAD_TYPE) body.push_back(unused_code());
      else body.push_back(pick_code(vt));
      case (vt)
        0: body.push_back($urandom_range(1) ? 8'($urandom) : 8'd0);
        1, 2: repeat (8) body.push_back(8'($urandom));
        default: begin
          lim = (vt == 3) ? lim_text : lim_blob;
          plen = $urandom_range((lim < max_pay) ? lim : max_pay);
          if (p == nprops - 1 && flaw == FLAW_LEN_RANGE && lim < 255) plen = lim + 1;
          body.push_back(8'(plen));
          if (plen <= lim) repeat (plen) body.push_back(8'($urandom));
        end
      endcase
    end
    if (flaw == FLAW_TRUNC && body.size() > 0) void'(body.pop_back());
    if (flaw == FLAW_EXTRA_BODY) body.push_back(8'($urandom));
    blen = 16'(body.size());
    if (flaw == FLAW_SHORT_BODY) blen = 16'($urandom_range(int'(id_len) + TIDLEN + 2));
    rec = {};
    for (int i = 0; i < 4; i++) rec.push_back(REC_MAGIC[8*i +: 8]);
    if (flaw == FLAW_MAGIC) rec[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    rec.push_back((flaw == FLAW_VERSION) ? 8'($urandom_range(2, 255)) : REC_VERSION);
    rec.push_back(id_len);
    rec.push_back(blen[7:0]); rec.push_back(blen[15:8]);
    if (flaw == FLAW_SHORT_BODY) while (body.size() > blen) void'(body.pop_back());
    foreach (body[i]) rec.push_back(body[i]);
    c = '1;
    foreach (rec[i]) c = crc_byte(c, rec[i]);
    c = ~c;
    if (flaw == FLAW_CRC) c ^= 32'(1) << $urandom_range(31);
    for (int i = 0; i < 4; i++) rec.push_back(c[8*i +: 8]);
    if (flaw == FLAW_CUT) repeat ($urandom_range(1, 6)) void'(rec.pop_back());
    if (flaw == FLAW_TAIL) repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom));
  endtask

  task automatic send_record(flaw_t flaw, int nprops, int max_pay);
    logic [7:0] rec[$];
    build_record(flaw, nprops, max_pay, rec);
    send_bytes(rec);
  endtask

  // a blob of noise of the given length, ending with last
  task automatic send_noise(int len);
    logic [7:0] rec[$];
    rec = {};
    repeat (len) rec.push_back(8'($urandom));
    send_bytes(rec);
  endtask

  // duplicate ids need the repeated id to be an earlier one: send explicitly
  task automatic send_dup_record();
    logic [7:0] rec[$], body[$];
    logic [31:0] c;
    body = {8'h41};
    repeat (TIDLEN) body.push_back(8'd0);
    body.push_back(8'h07); body.push_back(8'h09); body.push_back(8'd2);
    body.push_back(8'h34); body.push_back(8'h12); body.push_back(type_code[0]);
    body.push_back(8'd5);
    body.push_back(8'h34); body.push_back(8'h12); body.push_back(type_code[0]);
    body.push_back(8'd1);
    rec = {};
    for (int i = 0; i < 4; i++) rec.push_back(REC_MAGIC[8*i +: 8]);
    rec.push_back(REC_VERSION); rec.push_back(8'd1);
    rec.push_back(8'(body.size())); rec.push_back(8'd0);
    foreach (body[i]) rec.push_back(body[i]);
    c = '1;
    foreach (rec[i]) c = crc_byte(c, rec[i]);
    c = ~c;
    for (int i = 0; i < 4; i++) rec.push_back(c[8*i +: 8]);
    send_bytes(rec);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_record(FLAW_NONE, 2, 4);
    send_record(FLAW_ZERO_ID, 1, 2);
    send_dup_record();
    send_record(FLAW_LEN_RANGE, 1, 2);
    send_noise(1);
    send_noise(11);
  endtask

  // codes shared between types and limits at the extremes
  task automatic test_config_extremes();
    drain();
    write_reg(CFG_CODE_BOOL, 8'hFF);
    write_reg(CFG_CODE_S64, 8'h00);
    write_reg(CFG_CODE_U64, 8'h00);  // shadowed by the signed code
    write_reg(CFG_CODE_TEXT, 8'h80);
    write_reg(CFG_CODE_BLOB, 8'h7F);
    write_reg(CFG_ID_LIM, 8'd1);
    write_reg(CFG_TEXT_LIM, 8'd0);
    write_reg(CFG_BLOB_LIM, 8'd255);
    send_record(FLAW_NONE, 3, 40);
    send_record(FLAW_ID_SIZE, 0, 0);
    drain();
    write_reg(CFG_ID_LIM, 8'd255);
    write_reg(CFG_TEXT_LIM, 8'd255);
    write_reg(CFG_CODE_U64, 8'h33);
    send_record(FLAW_NONE, 1, 40);
    drain();
    write_reg(CFG_CODE_BOOL, 8'd0);
    write_reg(CFG_CODE_S64, 8'd1);
    write_reg(CFG_CODE_U64, 8'd2);
    write_reg(CFG_CODE_TEXT, 8'd3);
    write_reg(CFG_CODE_BLOB, 8'd4);
    write_reg(CFG_ID_LIM, 8'd8);
    write_reg(CFG_TEXT_LIM, 8'd12);
    write_reg(CFG_BLOB_LIM, 8'd12);
  endtask

  task automatic test_random(int n_bytes);
    int stop;
    int r;
    flaw_t f;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_noise($urandom_range(1, 20));
      end else begin
        f = (r < 30) ? FLAW_NONE : flaw_t'($urandom_range(1, FLAW_LAST - 1));
        if (f == FLAW_DUP_ID) send_dup_record();
        else send_record(f, $urandom_range(1, 3), 4);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output monitor and receiver stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    token_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected item kind %0d data %h", $realtime,
                 m_axis_tuser_o, m_axis_tdata_o[63:0]);
        fail_count++;
      end else begin
        e = pending_tokens.pop_front();
        if (m_axis_tuser_o !== e.kind || m_axis_tdata_o[63:0] !== e.data ||
            m_axis_tdata_o[79:64] !== e.fid || m_axis_tdata_o[82:80] !== e.vtype ||
            m_axis_tdata_o[85:83] !== e.status || m_axis_tlast_o !== e.fin ||
            m_axis_tdata_o[87:86] !== 2'b00) begin
          $display("%0t: expected kind %0d data %h fid %h vt %0d st %0d fin %0d",
                   $realtime, e.kind, e.data, e.fid, e.vtype, e.status, e.fin);
          $display("%0t:   actual kind %0d data %h fid %h vt %0d st %0d fin %0d",
                   $realtime, m_axis_tuser_o, m_axis_tdata_o[63:0],
                   m_axis_tdata_o[79:64], m_axis_tdata_o[82:80],
                   m_axis_tdata_o[85:83], m_axis_tlast_o);
          fail_count++;
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles with no accepted item on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL identity_record_parser");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 72;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CODE_BOOL;
    cfg_wdata_i = '0;
    type_code = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4};
    lim_ident = 8'd32; lim_text = 8'd32; lim_blob = 8'd32;
    clear_record();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_extremes();
    test_random(60);
    send_idle_pct = 72;
    recv_idle_pct = 16;
    test_random(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(60);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_tokens.size() == 0) begin
      $display("PASS identity_record_parser");
    end else begin
      $display("FAIL identity_record_parser");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/irp_pkg.sv
rtl/core/irp_ctrl.sv
rtl/core/irp_datapath.sv
rtl/core/identity_record_parser.sv
bench/identity_record_parser_tb.sv
